FILE: rtl/rrm_pkg.sv
// Package of types, constants and helper functions for the random rotation matrix block.
package rrm_pkg;

	localparam int FracW = 16;
	localparam int OutW = 16;
	localparam int CordicSteps = 24;
	localparam int QW = 34;
	localparam int SqW = 32;
	localparam int SqSteps = 32;
	localparam int SqPerStage = 4;
	localparam int SqStages = SqSteps / SqPerStage;

	localparam logic signed [QW-1:0] CordicGain = 34'sd652032874;
	localparam logic signed [QW-1:0] QOne = 34'sd1073741824;

	typedef logic signed [QW-1:0] q_t;

	typedef struct packed {
		logic [FracW-1:0] theta_frac;
		logic [FracW-1:0] phi_frac;
		logic [FracW-1:0] deflect_frac;
	} in_item_t;

	typedef struct packed {
		logic [OutW-1:0] m_r0c0;
		logic [OutW-1:0] m_r0c1;
		logic [OutW-1:0] m_r0c2;
		logic [OutW-1:0] m_r1c0;
		logic [OutW-1:0] m_r1c1;
		logic [OutW-1:0] m_r1c2;
		logic [OutW-1:0] m_r2c0;
		logic [OutW-1:0] m_r2c1;
		logic [OutW-1:0] m_r2c2;
	} out_item_t;

	// CORDIC state for one angle.
	typedef struct packed {
		q_t x;
		q_t y;
		logic signed [QW-1:0] acc;
		logic [1:0] quad;
	} cordic_t;

	// Square root state: remainder and partial root of a 64-bit radicand.
	typedef struct packed {
		logic [63:0] rad;
		logic [SqW+1:0] rem;
		logic [SqW-1:0] root;
	} sqrt_t;

	// Arctangent table in units of 2^-32 turn.
	function automatic logic signed [QW-1:0] atan_turn(input logic [4:0] i);
		logic signed [QW-1:0] v;
		begin
			unique case (i)
				5'd0: v = 34'sd536870912;
				5'd1: v = 34'sd316933406;
				5'd2: v = 34'sd167458907;
				5'd3: v = 34'sd85004756;
				5'd4: v = 34'sd42667331;
				5'd5: v = 34'sd21354465;
				5'd6: v = 34'sd10679838;
				5'd7: v = 34'sd5340245;
				5'd8: v = 34'sd2670163;
				5'd9: v = 34'sd1335087;
				5'd10: v = 34'sd667544;
				5'd11: v = 34'sd333772;
				5'd12: v = 34'sd166886;
				5'd13: v = 34'sd83443;
				5'd14: v = 34'sd41722;
				5'd15: v = 34'sd20861;
				5'd16: v = 34'sd10430;
				5'd17: v = 34'sd5215;
				5'd18: v = 34'sd2608;
				5'd19: v = 34'sd1304;
				5'd20: v = 34'sd652;
				5'd21: v = 34'sd326;
				5'd22: v = 34'sd163;
				5'd23: v = 34'sd81;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	// One CORDIC micro-rotation.
	function automatic cordic_t cordic_step(input cordic_t c, input logic [4:0] i);
		cordic_t n;
		q_t dx;
		q_t dy;
		begin
			dx = c.y >>> i;
			dy = c.x >>> i;
			n = c;
			if (!c.acc[QW-1]) begin
				n.x = c.x - dx;
				n.y = c.y + dy;
				n.acc = c.acc - atan_turn(i);
			end else begin
				n.x = c.x + dx;
				n.y = c.y - dy;
				n.acc = c.acc + atan_turn(i);
			end
			return n;
		end
	endfunction

	// One digit of a restoring square root, radicand consumed two bits at a time.
	function automatic sqrt_t sqrt_step(input sqrt_t s);
		sqrt_t n;
		logic [SqW+1:0] trial;
		logic [SqW+1:0] rem2;
		begin
			rem2 = {s.rem[SqW-1:0], s.rad[63:62]};
			trial = {s.root, 2'b01};
			n.rad = {s.rad[61:0], 2'b00};
			if (rem2 >= trial) begin
				n.rem = rem2 - trial;
				n.root = {s.root[SqW-2:0], 1'b1};
			end else begin
				n.rem = rem2;
				n.root = {s.root[SqW-2:0], 1'b0};
			end
			return n;
		end
	endfunction

	// Q4.30 product rounded back to Q4.30.
	function automatic q_t qmul(input q_t a, input q_t b);
		logic signed [2*QW-1:0] p;
		begin
			p = a * b + (68'sd1 <<< 29);
			return q_t'(p >>> 30);
		end
	endfunction

	// Q6.30 to saturated Q1.15.
	function automatic logic [OutW-1:0] to_q15(input logic signed [QW+1:0] v);
		logic signed [QW+1:0] q;
		begin
			q = (v + 36'sd16384) >>> 15;
			if (q > 36'sd32767) return 16'h7fff;
			else if (q < -36'sd32768) return 16'h8000;
			else return q[OutW-1:0];
		end
	endfunction

endpackage

FILE: rtl/rrm_stream_if.sv
// Valid/ready stream interface carrying one payload.
interface rrm_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/random_rotation_matrix_top.sv
// Pipelined random rotation matrix generator (Arvo's method) in fixed point.
// Throughput: one item per cycle unless stalled; 24 CORDIC stages and 8 four-digit
// square root stages run in parallel, followed by multiply stages A and B, sum
// stage C and output stage D.
// The whole pipeline advances together; a stall holds every stage.
// Reset clears all valid bits; data registers are not reset.
module random_rotation_matrix_top (
	input logic clk,
	input logic arst_n,
	rrm_stream_if.sink in_if,
	rrm_stream_if.source out_if
);
	import rrm_pkg::*;

	localparam int Front = CordicSteps + 1;
	localparam int Depth = Front + 4;

	logic adv;
	logic [Depth-1:0] vld_q;

	cordic_t ct_s [Front];
	cordic_t cp_s [Front];
	sqrt_t sr_s [Front];
	sqrt_t sv_s [Front];
	logic [FracW-1:0] bz_s [Front];

	// Pipeline advances whenever the last stage is empty or drained.
	assign adv = !vld_q[Depth-1] || out_if.ready;
	assign in_if.ready = adv;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[Depth-2:0], in_if.valid};
	end

	// Stage 0: capture, seed the CORDICs and the square roots.
	always_ff @(posedge clk) begin
		if (adv) begin
			ct_s[0] <= '{x: CordicGain, y: '0,
				acc: QW'({in_if.data.theta_frac[13:0], 16'h0}),
				quad: in_if.data.theta_frac[15:14]};
			cp_s[0] <= '{x: CordicGain, y: '0,
				acc: QW'({in_if.data.phi_frac[13:0], 16'h0}),
				quad: in_if.data.phi_frac[15:14]};
			sr_s[0] <= '{rad: {3'b0, in_if.data.deflect_frac, 45'b0}, rem: '0, root: '0};
			sv_s[0] <= '{rad: {2'b0, 32'h8000_0000 - {1'b0, in_if.data.deflect_frac, 15'b0},
				30'b0}, rem: '0, root: '0};
			bz_s[0] <= in_if.data.deflect_frac;
		end
	end

	// CORDIC and square root stages.
	for (genvar g = 0; g < CordicSteps; g++) begin : g_front
		always_ff @(posedge clk) begin
			if (adv) begin
				ct_s[g+1] <= cordic_step(ct_s[g], 5'(g));
				cp_s[g+1] <= cordic_step(cp_s[g], 5'(g));
				bz_s[g+1] <= bz_s[g];
				if (g < SqStages) begin
					sqrt_t a;
					sqrt_t b;
					a = sr_s[g];
					b = sv_s[g];
					for (int k = 0; k < SqPerStage; k++) begin
						a = sqrt_step(a);
						b = sqrt_step(b);
					end
					sr_s[g+1] <= a;
					sv_s[g+1] <= b;
				end else begin
					sr_s[g+1] <= sr_s[g];
					sv_s[g+1] <= sv_s[g];
				end
			end
		end
	end

	// Quadrant fix-up.
	q_t st, ctv, sp, cpv;
	always_comb begin
		unique case (ct_s[Front-1].quad)
			2'd0: begin st = ct_s[Front-1].y; ctv = ct_s[Front-1].x; end
			2'd1: begin st = ct_s[Front-1].x; ctv = -ct_s[Front-1].y; end
			2'd2: begin st = -ct_s[Front-1].y; ctv = -ct_s[Front-1].x; end
			default: begin st = -ct_s[Front-1].x; ctv = ct_s[Front-1].y; end
		endcase
		unique case (cp_s[Front-1].quad)
			2'd0: begin sp = cp_s[Front-1].y; cpv = cp_s[Front-1].x; end
			2'd1: begin sp = cp_s[Front-1].x; cpv = -cp_s[Front-1].y; end
			2'd2: begin sp = -cp_s[Front-1].y; cpv = -cp_s[Front-1].x; end
			default: begin sp = -cp_s[Front-1].x; cpv = cp_s[Front-1].y; end
		endcase
	end

	// Multiply stage A: V.
	q_t vx_s1, vy_s1, vz_s1, st_s1, ct_s1;
	logic [FracW-1:0] bz_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s1 <= qmul(sp, QW'(sr_s[Front-1].root));
			vy_s1 <= qmul(cpv, QW'(sr_s[Front-1].root));
			vz_s1 <= QW'(sv_s[Front-1].root);
			st_s1 <= st;
			ct_s1 <= ctv;
			bz_s1 <= bz_s[Front-1];
		end
	end

	// Multiply stage B: S partial products and V outer products.
	q_t p0_s2, p1_s2, p2_s2, p3_s2, vx_s2, vy_s2, vz_s2, st_s2, ct_s2;
	q_t xz_s2, yz_s2;
	logic [FracW-1:0] bz_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s2 <= qmul(vx_s1, ct_s1);
			p1_s2 <= qmul(vy_s1, st_s1);
			p2_s2 <= qmul(vx_s1, st_s1);
			p3_s2 <= qmul(vy_s1, ct_s1);
			xz_s2 <= qmul(vx_s1, vz_s1);
			yz_s2 <= qmul(vy_s1, vz_s1);
			vx_s2 <= vx_s1; vy_s2 <= vy_s1; vz_s2 <= vz_s1;
			st_s2 <= st_s1; ct_s2 <= ct_s1; bz_s2 <= bz_s1;
		end
	end

	// Stage C: S sums.
	q_t sx_s3, sy_s3, vx_s3, vy_s3, vz_s3, st_s3, ct_s3, xz_s3, yz_s3;
	logic [FracW-1:0] bz_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s3 <= p0_s2 - p1_s2;
			sy_s3 <= p2_s2 + p3_s2;
			vx_s3 <= vx_s2; vy_s3 <= vy_s2; vz_s3 <= vz_s2;
			st_s3 <= st_s2; ct_s3 <= ct_s2; bz_s3 <= bz_s2;
			xz_s3 <= xz_s2; yz_s3 <= yz_s2;
		end
	end

	// Stage D: last products, addition and subtraction, rounding and saturation.
	out_item_t res_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s4.m_r0c0 <= to_q15(36'(qmul(vx_s3, sx_s3)) - 36'(ct_s3));
			res_s4.m_r0c1 <= to_q15(36'(qmul(vx_s3, sy_s3)) - 36'(st_s3));
			res_s4.m_r0c2 <= to_q15(36'(xz_s3));
			res_s4.m_r1c0 <= to_q15(36'(qmul(vy_s3, sx_s3)) + 36'(st_s3));
			res_s4.m_r1c1 <= to_q15(36'(qmul(vy_s3, sy_s3)) - 36'(ct_s3));
			res_s4.m_r1c2 <= to_q15(36'(yz_s3));
			res_s4.m_r2c0 <= to_q15(36'(qmul(vz_s3, sx_s3)));
			res_s4.m_r2c1 <= to_q15(36'(qmul(vz_s3, sy_s3)));
			res_s4.m_r2c2 <= to_q15(36'(QOne) - 36'({bz_s3, 15'b0}));
		end
	end

	assign out_if.valid = vld_q[Depth-1];
	assign out_if.data = res_s4;

	// A stalled result stays valid.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_if.valid && !out_if.ready |=> out_if.valid)
		else $error("result dropped while stalled");
	// An input transfer is tracked by the first valid bit.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_if.valid && in_if.ready |=> vld_q[0])
		else $error("input transfer not tracked");
	// No advance while the output holds an untaken result.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_if.valid && !out_if.ready |-> !in_if.ready)
		else $error("pipeline advanced during stall");

endmodule
